// ===== src/evs_pkg.sv =====
// Shared types, constants and a helper function for the exhalation valve integral servo.
// Depends on nothing; every other file in src refers to it by scoped names.
package evs_pkg;

  // Defaults for the top-level parameters.
  localparam int POSITION_MAX_DEF  = 2000;
  localparam int FRACTION_BITS_DEF = 8;

  // Loop gains and scalers.
  localparam int ERR_GAIN   = 100;
  localparam int ERR_SCALER = 500;
  localparam int POS_GAIN   = 20;
  localparam int POS_SCALER = 1667;

  // Field and datapath widths.
  localparam int PRESS_W = 16;
  localparam int ERR_W   = PRESS_W + 1;
  localparam int MAG_W   = PRESS_W;
  localparam int SUM_W   = 32;
  localparam int POS_W   = 11;

  // The error scale error*100/500 reduces to error/5. The truncating divide by 5 is a
  // reciprocal multiply on the error magnitude, exact for every 16-bit magnitude.
  localparam int ERR_DIV    = ERR_SCALER / ERR_GAIN;
  localparam int ERR_SHIFT  = 19;
  localparam int ERR_MULT   = ((1 << ERR_SHIFT) + ERR_DIV - 1) / ERR_DIV;
  localparam int ERR_MULT_W = $clog2(ERR_MULT + 1);
  localparam int PROD_W     = MAG_W + ERR_MULT_W;
  localparam int STEP_W     = PROD_W - ERR_SHIFT;

  // Smallest integrator quotient whose position reaches at least one step.
  localparam int Q_LOW = (POS_SCALER + POS_GAIN - 1) / POS_GAIN;

  // Smallest integrator quotient whose position reaches the upper clamp.
  function automatic int q_high(input int pos_max);
    q_high = (POS_SCALER * pos_max + POS_GAIN - 1) / POS_GAIN;
  endfunction

  // Where the position taken from the integrator lies.
  typedef enum logic [1:0] {
    ZONE_MID  = 2'b00,
    ZONE_LOW  = 2'b01,
    ZONE_HIGH = 2'b10
  } zone_t;

  // Integrator commands for one transfer.
  typedef struct packed {
    logic clear;
    logic sample;
  } integ_ctrl_t;

  // Integrator step as sign and magnitude, before the fraction shift.
  typedef struct packed {
    logic              neg;
    logic [STEP_W-1:0] mag;
  } step_t;

endpackage

// ===== src/evs_integrator.sv =====
// Integrator register with clamp detection and anti-windup gating.
// Depends on evs_pkg for the step, command and zone types and the loop constants.
module evs_integrator #(
  parameter int POSITION_MAX  = evs_pkg::POSITION_MAX_DEF,
  parameter int FRACTION_BITS = evs_pkg::FRACTION_BITS_DEF,
  parameter int X_W           = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  input  evs_pkg::integ_ctrl_t  ctrl,
  input  evs_pkg::step_t        step,
  output evs_pkg::zone_t        zone,
  output logic [X_W-1:0]        x
);

  localparam int Q_HI = evs_pkg::q_high(POSITION_MAX);
  localparam logic signed [evs_pkg::SUM_W-1:0] Q_HI_S = evs_pkg::SUM_W'(Q_HI);
  localparam logic signed [evs_pkg::SUM_W-1:0] Q_LO_S = evs_pkg::SUM_W'(evs_pkg::Q_LOW);

  logic [evs_pkg::SUM_W-1:0]        integral_sum;
  logic [evs_pkg::SUM_W-1:0]        integral_sum_next;
  logic signed [evs_pkg::SUM_W-1:0] q;
  logic [evs_pkg::SUM_W-1:0]        step_ext;
  logic                             add;

  // Integer part of the integrator, rounded toward minus infinity.
  assign q = $signed(integral_sum) >>> FRACTION_BITS;

  // Clamp zone of the position derived from the integrator before this sample.
  always_comb begin
    if (q >= Q_HI_S) begin
      zone = evs_pkg::ZONE_HIGH;
    end else if (q < Q_LO_S) begin
      zone = evs_pkg::ZONE_LOW;
    end else begin
      zone = evs_pkg::ZONE_MID;
    end
  end

  // Scaled quotient for the position divider; only meaningful in the middle zone.
  assign x = X_W'(q[X_W-1:0] * X_W'(evs_pkg::POS_GAIN));

  // At a clamp, only a step pointing back into range is taken. A zero step adds nothing,
  // so the sign bit alone decides.
  always_comb begin
    case (zone)
      evs_pkg::ZONE_HIGH: add = step.neg;
      evs_pkg::ZONE_LOW:  add = !step.neg;
      default:            add = 1'b1;
    endcase
  end

  assign step_ext = evs_pkg::SUM_W'(step.mag) << FRACTION_BITS;

  // Next integrator value; the sum wraps modulo two to the width.
  always_comb begin
    integral_sum_next = integral_sum;
    if (ctrl.clear) begin
      integral_sum_next = '0;
    end else if (ctrl.sample && add) begin
      if (step.neg) begin
        integral_sum_next = integral_sum - step_ext;
      end else begin
        integral_sum_next = integral_sum + step_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else begin
      integral_sum <= integral_sum_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A clear command leaves the integrator at zero.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> integral_sum == '0)
    else $error("integrator not zero after clear");

  // At the upper clamp a non-negative step must not wind the integrator further.
  a_upper_hold: assert property (@(posedge clk) disable iff (rst)
    ctrl.sample && !ctrl.clear && zone == evs_pkg::ZONE_HIGH && !step.neg
      |=> $stable(integral_sum))
    else $error("integrator wound up past the upper clamp");

  // Without a command the integrator holds.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.clear && !ctrl.sample |=> $stable(integral_sum))
    else $error("integrator changed without a command");
`endif

endmodule

// ===== src/exhalation_valve_integral_servo.sv =====
// Top level of the exhalation valve integral servo: handshakes, pipeline and position divider.
// Depends on evs_pkg and evs_integrator.
//
//   channel  direction  handshake             payload
//   config   in         cfg_wr_en             cfg_wr_data (loop_enable)
//   input    in         in_valid / in_ready   mode, measured_pressure, target_pressure
//   output   out        out_valid / out_ready valve_position
//
// One item is accepted per cycle while in_ready is high; its position passes stages A, B, C and the output register.
// The integrator add and clamp compare form the only loop; both are combinational ahead of the integrator register.
// Stages are elastic: an item advances whenever the stage ahead is empty or moving,
// so up to four items are held while out_ready is low before in_ready drops.
// Clear items and samples taken while the loop is disabled give no result.
// Reset (synchronous) empties the pipeline, zeroes the integrator and disables the loop.
module exhalation_valve_integral_servo #(
  parameter int POSITION_MAX  = evs_pkg::POSITION_MAX_DEF,
  parameter int FRACTION_BITS = evs_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [evs_pkg::PRESS_W-1:0] measured_pressure,
  input  logic signed [evs_pkg::PRESS_W-1:0] target_pressure,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [evs_pkg::POS_W-1:0]         valve_position
);

  // Position divider: floor(x / 1667) as a reciprocal multiply, exact for every x below
  // 2^X_W, which covers all quotients below the upper clamp.
  localparam int X_W       = $clog2(evs_pkg::q_high(POSITION_MAX) * evs_pkg::POS_GAIN);
  localparam int DIV_SHIFT = X_W + $clog2(evs_pkg::POS_SCALER);
  localparam logic [63:0] DIV_MULT =
    ((64'd1 << DIV_SHIFT) + 64'(evs_pkg::POS_SCALER) - 64'd1) / 64'(evs_pkg::POS_SCALER);
  localparam int M_W    = DIV_SHIFT - $clog2(evs_pkg::POS_SCALER) + 1;
  localparam int POSP_W = X_W + M_W;

  logic loop_enable;

  // Stage registers.
  logic                                  a_valid;
  logic                                  a_mode;
  logic signed [evs_pkg::ERR_W-1:0]      a_err;
  logic                                  b_valid;
  logic                                  b_mode;
  logic                                  b_neg;
  logic [evs_pkg::PROD_W-1:0]            b_prod;
  logic                                  c_valid;
  evs_pkg::zone_t                        c_zone;
  logic [X_W-1:0]                        c_x;

  // Stage control.
  logic out_load;
  logic c_ready;
  logic b_ready;
  logic a_ready;
  logic b_fire;

  // Datapath.
  logic signed [evs_pkg::ERR_W-1:0]      err;
  logic signed [evs_pkg::ERR_W-1:0]      a_abs;
  logic [evs_pkg::PROD_W-1:0]            a_prod;
  evs_pkg::integ_ctrl_t                  ctrl;
  evs_pkg::step_t                        step;
  evs_pkg::zone_t                        zone;
  logic [X_W-1:0]                        x;
  logic [POSP_W-1:0]                     pos_prod;
  logic [evs_pkg::POS_W-1:0]             pos_mid;
  logic [evs_pkg::POS_W-1:0]             valve_position_next;

  // A stage takes a new item when it is empty or its item moves on.
  assign out_load = !out_valid || out_ready;
  assign c_ready  = !c_valid || out_load;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign b_fire   = b_valid && c_ready;

  // Error between target and measurement, one bit wider than the fields.
  assign err = evs_pkg::ERR_W'(target_pressure) - evs_pkg::ERR_W'(measured_pressure);

  // Magnitude of the error times the reciprocal of five.
  assign a_abs  = a_err[evs_pkg::ERR_W-1] ? -a_err : a_err;
  assign a_prod = evs_pkg::PROD_W'(a_abs[evs_pkg::MAG_W-1:0]) *
                  evs_pkg::PROD_W'(evs_pkg::ERR_MULT);

  // Integrator commands for the item leaving stage B.
  assign ctrl.clear  = b_fire && b_mode;
  assign ctrl.sample = b_fire && !b_mode && loop_enable;
  assign step.neg    = b_neg;
  assign step.mag    = b_prod[evs_pkg::ERR_SHIFT +: evs_pkg::STEP_W];

  evs_integrator #(
    .POSITION_MAX  (POSITION_MAX),
    .FRACTION_BITS (FRACTION_BITS),
    .X_W           (X_W)
  ) u_integrator (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .step (step),
    .zone (zone),
    .x    (x)
  );

  // Position from the registered quotient, or the clamp value.
  assign pos_prod = POSP_W'(c_x) * POSP_W'(DIV_MULT[M_W-1:0]);
  assign pos_mid  = evs_pkg::POS_W'(pos_prod >> DIV_SHIFT);

  always_comb begin
    case (c_zone)
      evs_pkg::ZONE_HIGH: valve_position_next = evs_pkg::POS_W'(POSITION_MAX);
      evs_pkg::ZONE_LOW:  valve_position_next = '0;
      default:            valve_position_next = pos_mid;
    endcase
  end

  // Control state: configuration and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        loop_enable <= cfg_wr_data;
      end
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid && !b_mode && loop_enable;
      end
      if (out_load) begin
        out_valid <= c_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mode <= mode;
      a_err  <= err;
    end
    if (b_ready) begin
      b_mode <= a_mode;
      b_neg  <= a_err[evs_pkg::ERR_W-1];
      b_prod <= a_prod;
    end
    if (c_ready) begin
      c_zone <= zone;
      c_x    <= x;
    end
    if (out_load) begin
      valve_position <= valve_position_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A delivered position never exceeds the upper clamp when the clamp fits the port.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (POSITION_MAX >= (1 << evs_pkg::POS_W)) ||
                  (valve_position <= evs_pkg::POS_W'(POSITION_MAX)))
    else $error("valve position above the upper clamp");

  // The input stalls only when every stage holds an item and the output is blocked.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> a_valid && b_valid && c_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");
`endif

endmodule
